@@ src/x86ra_pkg.sv @@
package x86ra_pkg;

  localparam int unsigned TypeW   = 6;
  localparam int unsigned WordW   = 64;
  localparam int unsigned HalfW   = 32;
  localparam int unsigned BytesW  = 4;
  localparam int unsigned StatusW = 2;
  localparam int unsigned LimitW  = 33;
  localparam int unsigned ShiftW  = 5;

  localparam logic [TypeW-1:0] R_NONE          = 6'd0;
  localparam logic [TypeW-1:0] R_64            = 6'd1;
  localparam logic [TypeW-1:0] R_PC32          = 6'd2;
  localparam logic [TypeW-1:0] R_PLT32         = 6'd4;
  localparam logic [TypeW-1:0] R_32            = 6'd10;
  localparam logic [TypeW-1:0] R_32S           = 6'd11;
  localparam logic [TypeW-1:0] R_TLSGD         = 6'd19;
  localparam logic [TypeW-1:0] R_GOTTPOFF      = 6'd22;
  localparam logic [TypeW-1:0] R_TPOFF32       = 6'd23;
  localparam logic [TypeW-1:0] R_PC64          = 6'd24;
  localparam logic [TypeW-1:0] R_GOTPCRELX     = 6'd41;
  localparam logic [TypeW-1:0] R_REX_GOTPCRELX = 6'd42;

  localparam logic [StatusW-1:0] ST_OK       = 2'd0;
  localparam logic [StatusW-1:0] ST_NONZERO  = 2'd1;
  localparam logic [StatusW-1:0] ST_OVERFLOW = 2'd2;
  localparam logic [StatusW-1:0] ST_UNKNOWN  = 2'd3;

  localparam logic [BytesW-1:0] WB_NONE = 4'd0;
  localparam logic [BytesW-1:0] WB_FOUR = 4'd4;
  localparam logic [BytesW-1:0] WB_EIGHT = 4'd8;

  localparam logic [0:0] CFG_TLS_SIZE  = 1'b0;
  localparam logic [0:0] CFG_TLS_ALIGN = 1'b1;

  typedef struct packed {
    logic sym_zero;
    logic cur_zero;
    logic low_zero;
    logic sect;
  } item_flags_t;

endpackage

@@ src/x86_64_relocation_apply_core.sv @@
// Throughput: one word per cycle while out_stall is low; three register
// stages (S+A add, the place / TLS subtractions and range checks,
// result select).
// A stage advances whenever the stage after it is empty or moving.
// Reset (rst, synchronous) empties the pipeline and clears tls_bytes and
// tls_align_log2 to zero.
module x86_64_relocation_apply_core
  import x86ra_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_index,
  input  logic [HalfW-1:0]      cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [TypeW-1:0]      reloc_type,
  input  logic [WordW-1:0]      symbol_value,
  input  logic signed [WordW-1:0] addend,
  input  logic [WordW-1:0]      place_address,
  input  logic [WordW-1:0]      existing_value,
  input  logic                  symbol_is_section,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [WordW-1:0]      patch_value,
  output logic [BytesW-1:0]     write_bytes,
  output logic [StatusW-1:0]    status
);

  logic [HalfW-1:0]  tls_bytes;
  logic [ShiftW-1:0] tls_align_log2;

  always_ff @(posedge clk) begin
    if (rst) begin
      tls_bytes      <= '0;
      tls_align_log2 <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TLS_SIZE:  tls_bytes      <= cfg_data;
        CFG_TLS_ALIGN: tls_align_log2 <= cfg_data[ShiftW-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic s1_valid, s2_valid;
  logic ready1, ready2, ready3;

  assign ready3   = !out_valid || !out_stall;
  assign ready2   = !s2_valid || ready3;
  assign ready1   = !s1_valid || ready2;
  assign in_stall = !ready1;

  // stage 1: S+A, target checks, TLS limit
  logic [LimitW-1:0] align_mask;
  logic [LimitW-1:0] tls_limit;

  always_comb begin
    align_mask = (LimitW'(1) << tls_align_log2) - LimitW'(1);
    tls_limit  = ({1'b0, tls_bytes} + align_mask) & ~align_mask;
  end

  logic [TypeW-1:0]  s1_type;
  logic [WordW-1:0]  s1_val;
  logic [WordW-1:0]  s1_place;
  logic [LimitW-1:0] s1_limit;
  item_flags_t       s1_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ready1) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && in_valid) begin
      s1_type           <= reloc_type;
      s1_val            <= symbol_value + $unsigned(addend);
      s1_place          <= place_address;
      s1_limit          <= tls_limit;
      s1_flags.sym_zero <= (symbol_value == '0);
      s1_flags.cur_zero <= (existing_value == '0);
      s1_flags.low_zero <= (existing_value[HalfW-1:0] == '0);
      s1_flags.sect     <= symbol_is_section;
    end
  end

  // stage 2: subtractions and range checks
  logic [TypeW-1:0] s2_type;
  logic [WordW-1:0] s2_val;
  logic [WordW-1:0] s2_pcrel;
  logic [HalfW-1:0] s2_tpoff;
  logic             s2_tp_ovf;
  logic             s2_zx_ovf;
  logic             s2_sx_ovf;
  item_flags_t      s2_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (ready2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && s1_valid) begin
      s2_type   <= s1_type;
      s2_val    <= s1_val;
      s2_pcrel  <= s1_val - s1_place;
      s2_tpoff  <= s1_val[HalfW-1:0] - s1_limit[HalfW-1:0];
      s2_tp_ovf <= (s1_val >= WordW'(s1_limit));
      s2_zx_ovf <= (s1_val[WordW-1:HalfW] != '0);
      s2_sx_ovf <= (s1_val[WordW-1:HalfW] != {HalfW{s1_val[HalfW-1]}});
      s2_flags  <= s1_flags;
    end
  end

  // stage 3: select
  logic [WordW-1:0]   value_sel;
  logic [BytesW-1:0]  bytes_sel;
  logic [StatusW-1:0] status_sel;

  always_comb begin
    value_sel  = '0;
    bytes_sel  = WB_NONE;
    status_sel = ST_OK;
    case (s2_type)
      R_NONE: ;
      R_64: begin
        if (!s2_flags.cur_zero) status_sel = ST_NONZERO;
        else begin
          value_sel = s2_val;
          bytes_sel = WB_EIGHT;
        end
      end
      R_PC64: begin
        if (!s2_flags.cur_zero) status_sel = ST_NONZERO;
        else begin
          value_sel = s2_pcrel;
          bytes_sel = WB_EIGHT;
        end
      end
      R_32: begin
        if (!s2_flags.low_zero) status_sel = ST_NONZERO;
        else if (s2_zx_ovf && !s2_flags.sect) status_sel = ST_OVERFLOW;
        else begin
          value_sel = {{HalfW{1'b0}}, s2_val[HalfW-1:0]};
          bytes_sel = WB_FOUR;
        end
      end
      R_32S: begin
        if (!s2_flags.low_zero) status_sel = ST_NONZERO;
        else if (s2_sx_ovf && !s2_flags.sect) status_sel = ST_OVERFLOW;
        else begin
          value_sel = {{HalfW{1'b0}}, s2_val[HalfW-1:0]};
          bytes_sel = WB_FOUR;
        end
      end
      R_TLSGD, R_GOTTPOFF, R_GOTPCRELX, R_REX_GOTPCRELX: begin
        if (s2_flags.sym_zero) status_sel = ST_OVERFLOW;
        else if (!s2_flags.low_zero) status_sel = ST_NONZERO;
        else begin
          value_sel = {{HalfW{1'b0}}, s2_pcrel[HalfW-1:0]};
          bytes_sel = WB_FOUR;
        end
      end
      R_PC32, R_PLT32: begin
        if (!s2_flags.low_zero) status_sel = ST_NONZERO;
        else begin
          value_sel = {{HalfW{1'b0}}, s2_pcrel[HalfW-1:0]};
          bytes_sel = WB_FOUR;
        end
      end
      R_TPOFF32: begin
        if (s2_tp_ovf) status_sel = ST_OVERFLOW;
        else begin
          value_sel = {{HalfW{1'b0}}, s2_tpoff};
          bytes_sel = WB_FOUR;
        end
      end
      default: status_sel = ST_UNKNOWN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready3) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3 && s2_valid) begin
      patch_value <= value_sel;
      write_bytes <= bytes_sel;
      status      <= status_sel;
    end
  end

  a_err_no_write: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> write_bytes == WB_NONE && patch_value == '0)
    else $error("error word carries a write");

  a_four_byte_masked: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_bytes == WB_FOUR |-> patch_value[WordW-1:HalfW] == '0)
    else $error("4-byte patch has upper bits set");

  a_bytes_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> write_bytes == WB_NONE || write_bytes == WB_FOUR
                  || write_bytes == WB_EIGHT)
    else $error("illegal write size");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && s2_valid && out_valid && out_stall)
    else $error("input stalled with room in pipeline");

endmodule
